FILE: hdl/rpc_pkg.sv
// Shared types and constants of the region protection classifier.
// Holds class codes, page flag bits, register indexes and the flag lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

    typedef logic [3:0] region_class_t;

    // Class codes of a result word.
    localparam region_class_t CLS_OWN_CODE    = 4'd0;
    localparam region_class_t CLS_OWN_RO      = 4'd1;
    localparam region_class_t CLS_OWN_RW      = 4'd2;
    localparam region_class_t CLS_OWN_STACK   = 4'd3;
    localparam region_class_t CLS_TRAMP       = 4'd4;
    localparam region_class_t CLS_OTHER_CODE  = 4'd5;
    localparam region_class_t CLS_OTHER_RO    = 4'd6;
    localparam region_class_t CLS_OTHER_RW    = 4'd7;
    localparam region_class_t CLS_OTHER_STACK = 4'd8;
    localparam region_class_t CLS_NONE        = 4'd9;

    // PAE big-page entry flag bits.
    localparam logic [63:0] FLAG_P   = 64'h0000_0000_0000_0001;
    localparam logic [63:0] FLAG_RW  = 64'h0000_0000_0000_0002;
    localparam logic [63:0] FLAG_PCD = 64'h0000_0000_0000_0010;
    localparam logic [63:0] FLAG_PSE = 64'h0000_0000_0000_0080;
    localparam logic [63:0] FLAG_NX  = 64'h8000_0000_0000_0000;

    // Fixed MMIO pages that must be mapped uncached.
    localparam logic [31:0] MMIO_LAPIC  = 32'hFEE0_0000;
    localparam logic [31:0] MMIO_IOAPIC = 32'hFEC0_0000;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SHARED_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHARED_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAMP_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRAMP_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRIV_A       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRIV_B       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRIV_C       = 3'd6;

    // Page entry flags for a class. Unmapped addresses are identity mapped
    // read-write, and the two interrupt controller pages are uncached.
    function automatic logic [63:0] pte_flags_for(input region_class_t cls,
                                                  input logic [31:0] addr);
        logic [63:0] f;
        f = '0;
        case (cls) inside
            CLS_OWN_CODE, CLS_TRAMP:
                f = FLAG_P | FLAG_PSE;
            CLS_OWN_RO:
                f = FLAG_P | FLAG_PSE | FLAG_NX;
            CLS_OWN_RW, CLS_OWN_STACK, CLS_OTHER_STACK:
                f = FLAG_P | FLAG_RW | FLAG_PSE | FLAG_NX;
            CLS_OTHER_CODE, CLS_OTHER_RO, CLS_OTHER_RW:
                f = '0;
            default:
            begin
                f = FLAG_P | FLAG_RW | FLAG_PSE;
                if (addr == MMIO_LAPIC || addr == MMIO_IOAPIC)
                begin
                    f = f | FLAG_PCD;
                end
            end
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the range bound table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/rpc_range_cmp.sv
// Half-open range compare unit shared by every range check of a classify.
// Reports whether an address lies in [lo, hi). No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpc_range_cmp (
    input  wire logic [31:0] addr,
    input  wire logic [31:0] lo,
    input  wire logic [31:0] hi,
    output logic             hit
);

    // An empty or inverted range can never satisfy both sides.
    assign hit = (addr >= lo) && (addr < hi);

endmodule

`default_nettype wire

FILE: hdl/region_protection_classifier.sv
// Region protection classifier top level: stream ports, configuration
// registers, range bound tables and the classify sequencer.
// Depends on rpc_pkg, rpc_ram and rpc_range_cmp.
//
// A bound write word produces no result. A classify word produces its
// result soonest when the very first range matches and latest when no
// range matches. Classify time is set by the single range comparator,
// which checks one stored range per cycle, then the shared region, then
// the trampoline region. The input takes no new word while a classify is
// in progress and is ready again once the result is loaded into the output
// register, which waits while the output is stalled.
// Reset: asynchronous, active low. Configuration registers take their
// documented reset values, and per-entry valid bits make every stored range
// read as empty, so no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module region_protection_classifier #(
    parameter int NUM_DOMAINS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input words.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: domain[3:0], region_kind[5:4], bound_sel[6], value[38:7], zero pad[39]
    input  wire logic [39:0] s_axis_tdata,
    // tuser: mode (0 writes a bound, 1 classifies an address)
    input  wire logic        s_axis_tuser,

    // Result words.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: region_class[3:0], pte_flags[67:4], zero pad[71:68]
    output logic      [71:0] m_axis_tdata,

    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Table geometry: four ranges per domain, one start and one end bound
    // each, kept in two RAMs addressed by {domain, kind}.
    localparam int DomW   = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
    localparam int RangeN = NUM_DOMAINS * 4;
    localparam int AW     = DomW + 2;
    localparam int TblN   = 1 << AW;
    localparam int CntW   = AW + 1;
    localparam logic [AW-1:0]   LastIdx  = AW'(RangeN - 1);
    localparam logic [CntW-1:0] IssueEnd = CntW'(RangeN);

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_SHARED = 3'd2;
    localparam logic [2:0] ST_TRAMP  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // Input word fields.
    logic        in_mode;
    logic [3:0]  in_domain;
    logic [1:0]  in_kind;
    logic        in_sel;
    logic [31:0] in_value;
    logic        in_acc;

    assign in_mode   = s_axis_tuser;
    assign in_domain = s_axis_tdata[3:0];
    assign in_kind   = s_axis_tdata[5:4];
    assign in_sel    = s_axis_tdata[6];
    assign in_value  = s_axis_tdata[38:7];
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    // Configuration registers, always ready; unknown indexes are dropped.
    // Writes must arrive only while the block is idle; it does not enforce this.
    logic [31:0] shared_start_reg;
    logic [31:0] shared_end_reg;
    logic [31:0] tramp_start_reg;
    logic [31:0] tramp_end_reg;
    logic [3:0]  priv_a_reg;
    logic [3:0]  priv_b_reg;
    logic [3:0]  priv_c_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_start_reg <= '0;
            shared_end_reg   <= '0;
            tramp_start_reg  <= '0;
            tramp_end_reg    <= '0;
            priv_a_reg       <= 4'd0;
            priv_b_reg       <= 4'd1;
            priv_c_reg       <= 4'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rpc_pkg::REG_SHARED_START: shared_start_reg <= cfg_data;
                rpc_pkg::REG_SHARED_END:   shared_end_reg   <= cfg_data;
                rpc_pkg::REG_TRAMP_START:  tramp_start_reg  <= cfg_data;
                rpc_pkg::REG_TRAMP_END:    tramp_end_reg    <= cfg_data;
                rpc_pkg::REG_PRIV_A:       priv_a_reg       <= cfg_data[3:0];
                rpc_pkg::REG_PRIV_B:       priv_b_reg       <= cfg_data[3:0];
                rpc_pkg::REG_PRIV_C:       priv_c_reg       <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer registers.
    logic [2:0]              state_reg, state_next;
    logic [CntW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [3:0]              dom_reg, dom_next;
    logic [31:0]             addr_reg, addr_next;
    rpc_pkg::region_class_t  cls_reg, cls_next;
    logic                    out_vld_reg, out_vld_next;
    rpc_pkg::region_class_t  out_cls_reg, out_cls_next;
    logic [63:0]             out_flags_reg, out_flags_next;

    // Bound writes. Writes to a domain outside the table are dropped.
    logic          wr_dom_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    assign wr_dom_ok = ({1'b0, in_domain} < 5'(NUM_DOMAINS));
    assign wr_en     = in_acc && !in_mode && wr_dom_ok;
    assign wr_addr   = {in_domain[DomW-1:0], in_kind};

    // Table reads: one range per cycle while the scan still has ranges to
    // issue. The valid bits are registered together with the RAM read data.
    logic          issued_all;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   ram_start_q;
    logic [31:0]   ram_end_q;

    assign issued_all = (idx_reg == IssueEnd);
    assign rd_en      = (state_reg == ST_SCAN) && !issued_all;
    assign rd_addr    = idx_reg[AW-1:0];

    rpc_ram #(
        .WIDTH (32),
        .DEPTH (TblN)
    ) u_start_ram (
        .clk   (clk),
        .we    (wr_en && !in_sel),
        .waddr (wr_addr),
        .wdata (in_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_start_q)
    );

    rpc_ram #(
        .WIDTH (32),
        .DEPTH (TblN)
    ) u_end_ram (
        .clk   (clk),
        .we    (wr_en && in_sel),
        .waddr (wr_addr),
        .wdata (in_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_end_q)
    );

    // A bound that was never written reads as zero, so a range whose end bound
    // was never written stays empty exactly as after reset.
    logic [TblN-1:0]   vld_start_reg;
    logic [TblN-1:0]   vld_end_reg;
    logic              rd_vs_reg;
    logic              rd_ve_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_start_reg <= '0;
            vld_end_reg   <= '0;
            rd_vs_reg     <= 1'b0;
            rd_ve_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en && !in_sel)
            begin
                vld_start_reg[wr_addr] <= 1'b1;
            end
            if (wr_en && in_sel)
            begin
                vld_end_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vs_reg <= vld_start_reg[rd_addr];
                rd_ve_reg <= vld_end_reg[rd_addr];
            end
        end
    end

    logic [31:0] tbl_start;
    logic [31:0] tbl_end;

    assign tbl_start = rd_vs_reg ? ram_start_q : '0;
    assign tbl_end   = rd_ve_reg ? ram_end_q : '0;

    // The one comparator walks the stored ranges, then the shared region,
    // then the trampoline region.
    logic [31:0] cmp_lo;
    logic [31:0] cmp_hi;
    logic        cmp_hit;

    always_comb
    begin
        case (state_reg)
            ST_SCAN:
            begin
                cmp_lo = tbl_start;
                cmp_hi = tbl_end;
            end
            ST_SHARED:
            begin
                cmp_lo = shared_start_reg;
                cmp_hi = shared_end_reg;
            end
            default:
            begin
                cmp_lo = tramp_start_reg;
                cmp_hi = tramp_end_reg;
            end
        endcase
    end

    rpc_range_cmp u_cmp (
        .addr (addr_reg),
        .lo   (cmp_lo),
        .hi   (cmp_hi),
        .hit  (cmp_hit)
    );

    // The range under compare belongs to the requester when its domain
    // index matches; a requester outside the table never owns a range.
    logic [1:0] cmp_kind;
    logic       cmp_own;
    logic       dom_priv;

    assign cmp_kind = cmp_idx_reg[1:0];
    assign cmp_own  = (dom_reg == 4'(cmp_idx_reg[AW-1:2]));
    assign dom_priv = (dom_reg == priv_a_reg) || (dom_reg == priv_b_reg) ||
                      (dom_reg == priv_c_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        dom_next       = dom_reg;
        addr_next      = addr_reg;
        cls_next       = cls_reg;
        out_vld_next   = out_vld_reg;
        out_cls_next   = out_cls_reg;
        out_flags_next = out_flags_reg;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_mode)
                begin
                    dom_next     = in_domain;
                    addr_next    = in_value;
                    idx_next     = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_vld_reg && cmp_hit)
                begin
                    // First matching range wins.
                    cls_next     = cmp_own ? {2'b00, cmp_kind}
                                           : rpc_pkg::CLS_OTHER_CODE + {2'b00, cmp_kind};
                    cmp_vld_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LastIdx))
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = ST_SHARED;
                end
                else if (!issued_all)
                begin
                    cmp_idx_next = idx_reg[AW-1:0];
                    cmp_vld_next = 1'b1;
                    idx_next     = idx_reg + CntW'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
            end
            ST_SHARED:
            begin
                if (cmp_hit)
                begin
                    cls_next   = dom_priv ? rpc_pkg::CLS_OWN_RW : rpc_pkg::CLS_OWN_RO;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_TRAMP;
                end
            end
            ST_TRAMP:
            begin
                cls_next   = cmp_hit ? rpc_pkg::CLS_TRAMP : rpc_pkg::CLS_NONE;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait here until the output register is free.
                if (!m_axis_tvalid || m_axis_tready)
                begin
                    out_vld_next   = 1'b1;
                    out_cls_next   = cls_reg;
                    out_flags_next = rpc_pkg::pte_flags_for(cls_reg, addr_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_idx_reg <= cmp_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dom_reg       <= dom_next;
        addr_reg      <= addr_next;
        cls_reg       <= cls_next;
        out_cls_reg   <= out_cls_next;
        out_flags_reg <= out_flags_next;
    end

    // Bound writes never occupy the sequencer, so the input is ready whenever
    // no classify is in progress, even while a result still waits.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, out_flags_reg, out_cls_reg};

    // A new result only appears after the sequencer has settled its class.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result word raised outside the done state");

    // A classify word always starts a range scan.
    a_classify_scans: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_mode |=> state_reg == ST_SCAN)
        else $error("classify word did not start a scan");

    // A bound write never occupies the sequencer.
    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !in_mode |=> state_reg == ST_IDLE)
        else $error("bound write left the idle state");

    // Pending compares exist only during the scan.
    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> state_reg == ST_SCAN)
        else $error("range compare pending outside the scan");

    // The settled class is always a defined code.
    a_class_defined: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> cls_reg <= rpc_pkg::CLS_NONE)
        else $error("undefined class code settled");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the region protection classifier.
// Drives bound-write and classify words, predicts each result word and compares it.
// Depends on rpc_pkg and region_protection_classifier.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_DOMAINS = 8;
    localparam int BOUND_WORDS = NUM_DOMAINS * 8;
    localparam int CYCLE_LIMIT = 300000;
    // Bound writes give no result, so the block is left this long after the last
    // result before a register is written.
    localparam int DRAIN_CYCLES = 4 * NUM_DOMAINS + 15;
    localparam int MAX_REPORTS = 100;

    // Input word codes.
    localparam logic MODE_WRITE    = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;
    localparam logic BOUND_START   = 1'b0;
    localparam logic BOUND_END     = 1'b1;
    localparam logic [1:0] KIND_CODE  = 2'd0;
    localparam logic [1:0] KIND_RO    = 2'd1;
    localparam logic [1:0] KIND_RW    = 2'd2;
    localparam logic [1:0] KIND_STACK = 2'd3;
    // Index past the register list; the block drops such writes.
    localparam logic [rpc_pkg::CFG_IDX_W-1:0] REG_RESERVED = 3'd7;

    typedef struct packed {
        rpc_pkg::region_class_t cls;
        logic [63:0]            flags;
    } mapping_t;

    logic clk;
    logic rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    // Shadow copy of the block's state and registers.
    logic [31:0] bound_mem [BOUND_WORDS];
    logic [31:0] shared_lo, shared_hi, tramp_lo, tramp_hi;
    logic [3:0]  priv_a, priv_b, priv_c;

    mapping_t expected_mappings [$];
    int  error_count;
    int  cycle_count;
    int  rx_hold;
    bit  tx_fast;
    bit  rx_fast;

    region_protection_classifier #(
        .NUM_DOMAINS(NUM_DOMAINS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Works out the class and page flags of one address for a requesting domain.
    // Stored ranges go first, lowest domain and kind first, then the shared
    // region, then the trampoline.
    function automatic mapping_t predict_mapping(input logic [3:0] dom,
                                                 input logic [31:0] addr);
        mapping_t m;
        int d;
        int k;
        int slot;
        bit found;
        found = 1'b0;
        m.cls = rpc_pkg::CLS_NONE;
        for (d = 0; d < NUM_DOMAINS; d++)
        begin
            for (k = 0; k < 4; k++)
            begin
                slot = (d * 4 + k) * 2;
                if (!found && addr >= bound_mem[slot] && addr < bound_mem[slot + 1])
                begin
                    found = 1'b1;
                    if (d == int'(dom))
                        m.cls = rpc_pkg::region_class_t'(rpc_pkg::CLS_OWN_CODE + k);
                    else
                        m.cls = rpc_pkg::region_class_t'(rpc_pkg::CLS_OTHER_CODE + k);
                end
            end
        end
        if (!found && addr >= shared_lo && addr < shared_hi)
        begin
            found = 1'b1;
            if (dom == priv_a || dom == priv_b || dom == priv_c)
                m.cls = rpc_pkg::CLS_OWN_RW;
            else
                m.cls = rpc_pkg::CLS_OWN_RO;
        end
        if (!found && addr >= tramp_lo && addr < tramp_hi)
            m.cls = rpc_pkg::CLS_TRAMP;

        case (m.cls)
            rpc_pkg::CLS_OWN_CODE, rpc_pkg::CLS_TRAMP:
                m.flags = rpc_pkg::FLAG_P | rpc_pkg::FLAG_PSE;
            rpc_pkg::CLS_OWN_RO:
                m.flags = rpc_pkg::FLAG_P | rpc_pkg::FLAG_PSE | rpc_pkg::FLAG_NX;
            rpc_pkg::CLS_OWN_RW, rpc_pkg::CLS_OWN_STACK, rpc_pkg::CLS_OTHER_STACK:
                m.flags = rpc_pkg::FLAG_P | rpc_pkg::FLAG_RW | rpc_pkg::FLAG_PSE |
                          rpc_pkg::FLAG_NX;
            rpc_pkg::CLS_OTHER_CODE, rpc_pkg::CLS_OTHER_RO, rpc_pkg::CLS_OTHER_RW:
                m.flags = 64'd0;
            default:
            begin
                m.flags = rpc_pkg::FLAG_P | rpc_pkg::FLAG_RW | rpc_pkg::FLAG_PSE;
                if (addr == rpc_pkg::MMIO_LAPIC || addr == rpc_pkg::MMIO_IOAPIC)
                    m.flags = m.flags | rpc_pkg::FLAG_PCD;
            end
        endcase
        return m;
    endfunction

    // Sends one input word, after a random gap unless sending fast, and updates
    // the prediction at the edge where the word is taken.
    task automatic send_word(input logic mode, input logic [3:0] dom,
                             input logic [1:0] kind, input logic sel,
                             input logic [31:0] val);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, val, sel, kind, dom};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (mode == MODE_WRITE)
        begin
            if (dom < NUM_DOMAINS)
                bound_mem[(int'(dom) * 4 + int'(kind)) * 2 + int'(sel)] = val;
        end
        else
        begin
            expected_mappings.push_back(predict_mapping(dom, val));
        end
    endtask

    task automatic write_range(input logic [3:0] dom, input logic [1:0] kind,
                               input logic [31:0] lo, input logic [31:0] hi);
        send_word(MODE_WRITE, dom, kind, BOUND_START, lo);
        send_word(MODE_WRITE, dom, kind, BOUND_END, hi);
    endtask

    // Classify with random values in the fields that the block ignores.
    task automatic classify(input logic [3:0] dom, input logic [31:0] addr);
        send_word(MODE_CLASSIFY, dom, 2'($urandom), 1'($urandom), addr);
    endtask

    // Holds the sender until every result is back and the block is idle.
    task automatic drain_and_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_mappings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            rpc_pkg::REG_SHARED_START: shared_lo = data;
            rpc_pkg::REG_SHARED_END:   shared_hi = data;
            rpc_pkg::REG_TRAMP_START:  tramp_lo = data;
            rpc_pkg::REG_TRAMP_END:    tramp_hi = data;
            rpc_pkg::REG_PRIV_A:       priv_a = data[3:0];
            rpc_pkg::REG_PRIV_B:       priv_b = data[3:0];
            rpc_pkg::REG_PRIV_C:       priv_c = data[3:0];
            default:          ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result words: stall at random, then compare each word with the oldest
    // expectation.
    always @(posedge clk)
    begin
        mapping_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_mappings.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result word with none expected: class %0d flags %h",
                                 $time, m_axis_tdata[3:0], m_axis_tdata[67:4]);
                end
                else
                begin
                    want = expected_mappings.pop_front();
                    if (m_axis_tdata[3:0] !== want.cls)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: region_class expected %0d actual %0d",
                                     $time, want.cls, m_axis_tdata[3:0]);
                    end
                    if (m_axis_tdata[67:4] !== want.flags)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: pte_flags expected %h actual %h",
                                     $time, want.flags, m_axis_tdata[67:4]);
                    end
                end
                rx_hold = rx_fast ? 0 : $urandom_range(0, 9);
            end
            else if (rx_hold > 0)
            begin
                rx_hold = rx_hold - 1;
            end
            m_axis_tready <= (rx_hold == 0);
        end
    end

    // All ranges and both fixed regions are empty after reset, so every
    // address falls through to the identity mapping.
    task automatic test_reset_state();
        classify(4'd0, 32'h0000_0000);
        classify(4'd15, 32'hFFFF_FFFF);
        classify(4'd1, rpc_pkg::MMIO_LAPIC);
        classify(4'd2, rpc_pkg::MMIO_IOAPIC);
        classify(4'd3, rpc_pkg::MMIO_LAPIC + 32'd1);
        drain_and_idle();
    endtask

    task automatic test_directed_ranges();
        write_reg(rpc_pkg::REG_SHARED_START, 32'h4000_0000);
        write_reg(rpc_pkg::REG_SHARED_END, 32'h5000_0000);
        write_reg(rpc_pkg::REG_TRAMP_START, 32'h0010_0000);
        write_reg(rpc_pkg::REG_TRAMP_END, 32'h0020_0000);
        write_reg(rpc_pkg::REG_PRIV_A, 32'd3);
        write_reg(rpc_pkg::REG_PRIV_B, 32'd5);
        write_reg(rpc_pkg::REG_PRIV_C, 32'd12);

        write_range(4'd0, KIND_CODE, 32'h0000_1000, 32'h0000_2000);
        // Overlaps domain 0 code; the lower domain must win where both hold.
        write_range(4'd3, KIND_RW, 32'h0000_1800, 32'h0000_3000);
        write_range(4'd0, KIND_STACK, 32'hFFFF_F000, 32'hFFFF_FFFF);
        // Inverted range never matches.
        write_range(4'd7, KIND_RO, 32'h0000_9000, 32'h0000_8000);
        // Domain beyond the table: the write is dropped.
        write_range(4'd9, KIND_CODE, 32'h4000_0000, 32'h5000_0000);

        classify(4'd0, 32'h0000_1000);
        classify(4'd3, 32'h0000_1800);
        classify(4'd3, 32'h0000_2000);
        classify(4'd5, 32'h0000_2FFF);
        classify(4'd0, 32'hFFFF_FFFE);
        classify(4'd6, 32'hFFFF_F000);
        classify(4'd2, 32'hFFFF_FFFF);
        classify(4'd7, 32'h0000_8800);
        classify(4'd3, 32'h4000_0000);
        classify(4'd4, 32'h4FFF_FFFF);
        classify(4'd12, 32'h4800_0000);
        classify(4'd9, 32'h0000_1000);
        classify(4'd15, 32'h4000_0000);
        classify(4'd1, 32'h0010_0000);
        classify(4'd1, 32'h0020_0000);
        classify(4'd1, rpc_pkg::MMIO_LAPIC);
        classify(4'd8, rpc_pkg::MMIO_IOAPIC);
        drain_and_idle();
    endtask

    // Whole-space regions, all privileged registers at the top value, a write
    // to an unused register index, then an inverted shared region.
    task automatic test_config_extremes();
        write_reg(rpc_pkg::REG_SHARED_START, 32'h0000_0000);
        write_reg(rpc_pkg::REG_SHARED_END, 32'hFFFF_FFFF);
        write_reg(rpc_pkg::REG_TRAMP_START, 32'h0000_0000);
        write_reg(rpc_pkg::REG_TRAMP_END, 32'hFFFF_FFFF);
        write_reg(rpc_pkg::REG_PRIV_A, 32'hFFFF_FFFF);
        write_reg(rpc_pkg::REG_PRIV_B, 32'h0000_000F);
        write_reg(rpc_pkg::REG_PRIV_C, 32'hFFFF_FFFF);
        write_reg(REG_RESERVED, 32'h0000_0000);
        classify(4'd15, 32'h7000_0000);
        classify(4'd0, 32'h7000_0000);
        classify(4'd1, rpc_pkg::MMIO_LAPIC);
        classify(4'd1, 32'hFFFF_FFFF);
        drain_and_idle();

        write_reg(rpc_pkg::REG_SHARED_START, 32'hFFFF_FFFF);
        write_reg(rpc_pkg::REG_SHARED_END, 32'h0000_0000);
        write_reg(rpc_pkg::REG_PRIV_A, 32'h0000_0000);
        write_reg(rpc_pkg::REG_PRIV_B, 32'h0000_0000);
        write_reg(rpc_pkg::REG_PRIV_C, 32'h0000_0000);
        classify(4'd0, 32'h7000_0000);
        classify(4'd4, rpc_pkg::MMIO_IOAPIC);
        drain_and_idle();
    endtask

    task automatic random_region(input logic [rpc_pkg::CFG_IDX_W-1:0] lo_idx,
                                 input logic [rpc_pkg::CFG_IDX_W-1:0] hi_idx);
        logic [31:0] base;
        base = $urandom;
        case ($urandom_range(0, 4))
            0:
            begin
                write_reg(lo_idx, 32'h0000_0000);
                write_reg(hi_idx, 32'hFFFF_FFFF);
            end
            1:
            begin
                write_reg(lo_idx, base);
                write_reg(hi_idx, base - 32'($urandom_range(0, 16)));
            end
            default:
            begin
                write_reg(lo_idx, base);
                write_reg(hi_idx, base + 32'($urandom_range(1, 32'h1000_0000)));
            end
        endcase
    endtask

    // Addresses mostly sit on or next to a stored bound or a fixed region bound,
    // so that the edges of every range and region get hit.
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        logic [31:0] nudge;
        nudge = 32'($urandom_range(0, 2)) - 32'd1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: a = bound_mem[$urandom_range(0, BOUND_WORDS - 1)] + nudge;
            5:             a = ($urandom_range(0, 1) ? shared_lo : shared_hi) + nudge;
            6:             a = ($urandom_range(0, 1) ? tramp_lo : tramp_hi) + nudge;
            7:             a = $urandom_range(0, 1) ? rpc_pkg::MMIO_LAPIC
                                                    : rpc_pkg::MMIO_IOAPIC;
            default:       a = $urandom;
        endcase
        return a;
    endfunction

    // One phase: new register settings while idle, then a mix of range
    // loads, stray bound writes and classify words.
    task automatic test_random_phase(input int n_items);
        int i;
        int pick;
        logic [3:0]  dom;
        logic [31:0] lo;
        logic [31:0] span;
        random_region(rpc_pkg::REG_SHARED_START, rpc_pkg::REG_SHARED_END);
        random_region(rpc_pkg::REG_TRAMP_START, rpc_pkg::REG_TRAMP_END);
        write_reg(rpc_pkg::REG_PRIV_A, $urandom);
        write_reg(rpc_pkg::REG_PRIV_B, $urandom);
        write_reg(rpc_pkg::REG_PRIV_C, $urandom);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_RESERVED, $urandom);

        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
        i = 0;
        while (i < n_items)
        begin
            pick = $urandom_range(0, 99);
            dom = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, NUM_DOMAINS - 1));
            if (pick < 25)
            begin
                lo = $urandom;
                case ($urandom_range(0, 5))
                    0:       span = 32'd0;
                    1:       span = 32'($urandom_range(1, 16));
                    default: span = 32'($urandom_range(1, 32'h0100_0000));
                endcase
                write_range(dom, 2'($urandom), lo, lo + span);
                if (dom < NUM_DOMAINS)
                    i += 2;
            end
            else if (pick < 33)
            begin
                send_word(MODE_WRITE, dom, 2'($urandom), 1'($urandom), $urandom);
                if (dom < NUM_DOMAINS)
                    i += 1;
            end
            else
            begin
                classify(4'($urandom), pick_address());
                i += 1;
            end
            // Flip the idling pattern now and then so runs of full rate occur.
            if ($urandom_range(0, 49) == 0)
                tx_fast = !tx_fast;
            if ($urandom_range(0, 49) == 0)
                rx_fast = !rx_fast;
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        drain_and_idle();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        rx_hold = 0;
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        foreach (bound_mem[j])
            bound_mem[j] = 32'd0;
        shared_lo = 32'd0;
        shared_hi = 32'd0;
        tramp_lo = 32'd0;
        tramp_hi = 32'd0;
        priv_a = 4'd0;
        priv_b = 4'd1;
        priv_c = 4'd2;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_ranges();
        test_config_extremes();
        repeat (6) test_random_phase(100);

        drain_and_idle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
